// ===== src/rsn_pkg.sv =====
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared constants and controller/datapath command types for the
// row-normalized cumulative distribution unit.
// ----------------------------------------------------------------------------
package rsn_pkg;

  localparam int MaxGroups = 64;
  localparam int IdxW      = $clog2(MaxGroups);
  localparam int CountW    = IdxW + 1;
  localparam int ElemW     = 32;
  localparam int TotalW    = 38;
  localparam int QuotW     = 32;
  localparam int BitCntW   = $clog2(QuotW);

  localparam logic [0:0] RegNumGroups = 1'b0;

  typedef struct packed {
    logic            load;       // store element, add to total
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] raddr;
    logic            acc;        // add buffer word to prefix, seed divider
    logic            div_step;
    logic            div_first;
    logic            clear_row;
  } cmd_t;

  typedef struct packed {
    logic zero_total;
  } status_t;

endpackage

// ===== src/row_sum_normalize_cdf_unit.sv =====
// ----------------------------------------------------------------------------
// row_sum_normalize_cdf_unit
// Buffers one row of Q16.16 elements and emits its cumulative distribution
// in Q1.31, one result per element, normalized by the row sum.
//
//   channel   signals                                   handshake
//   input     start, busy, element_value                start && !busy
//   result    valid, cdf_value, row_total,              valid, one cycle
//             zero_sum, row_last
//   config    psel, penable, pwrite, paddr, pwdata,      APB, pready tied high
//             prdata, pready
//
// elements of a row are taken one per cycle while loading
// each result passes read, accumulate, the 1-bit-per-cycle divider and output
// (no divider steps when the row sum is zero); busy stays high until the last result
// reset clears the row count, total and num_groups (to 64)
// results cannot be held off; valid lasts exactly one cycle per result
// ----------------------------------------------------------------------------
module row_sum_normalize_cdf_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rsn_pkg::ElemW-1:0]   element_value,
  output logic                        valid,
  output logic [rsn_pkg::QuotW-1:0]   cdf_value,
  output logic [rsn_pkg::TotalW-1:0]  row_total,
  output logic                        zero_sum,
  output logic                        row_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rsn_pkg::cmd_t               cmd;
  rsn_pkg::status_t            status;
  logic [rsn_pkg::CountW-1:0]  num_groups;
  logic [rsn_pkg::CountW-1:0]  eff_len;
  logic                        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == rsn_pkg::RegNumGroups) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_groups <= rsn_pkg::CountW'(rsn_pkg::MaxGroups);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      num_groups <= pwdata[rsn_pkg::CountW-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32-rsn_pkg::CountW){1'b0}}, num_groups} : '0;

  // zero length acts as one, anything past the buffer depth as full depth
  always_comb begin
    if (num_groups == '0) begin
      eff_len = rsn_pkg::CountW'(1);
    end else if (num_groups > rsn_pkg::CountW'(rsn_pkg::MaxGroups)) begin
      eff_len = rsn_pkg::CountW'(rsn_pkg::MaxGroups);
    end else begin
      eff_len = num_groups;
    end
  end

  rsn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .eff_len (eff_len),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .valid   (valid),
    .row_last(row_last)
  );

  rsn_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .element_value(element_value),
    .cdf_value    (cdf_value),
    .row_total    (row_total),
    .zero_sum     (zero_sum)
  );

endmodule

// ===== src/rsn_ram.sv =====
// ----------------------------------------------------------------------------
// rsn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rsn_datapath.sv =====
// ----------------------------------------------------------------------------
// rsn_datapath
// Row buffer, running total, prefix sum and bit-serial restoring divider.
// ----------------------------------------------------------------------------
module rsn_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  rsn_pkg::cmd_t               cmd,
  output rsn_pkg::status_t            status,
  input  logic [rsn_pkg::ElemW-1:0]   element_value,
  output logic [rsn_pkg::QuotW-1:0]   cdf_value,
  output logic [rsn_pkg::TotalW-1:0]  row_total,
  output logic                        zero_sum
);

  logic [rsn_pkg::ElemW-1:0]  rdata;
  logic [rsn_pkg::TotalW-1:0] total;
  logic [rsn_pkg::TotalW-1:0] prefix;
  logic [rsn_pkg::TotalW-1:0] prefix_next;
  logic [rsn_pkg::TotalW:0]   rem;
  logic [rsn_pkg::TotalW:0]   rem_shift;
  logic                       rem_ge;
  logic [rsn_pkg::QuotW-1:0]  quot;

  rsn_ram #(
    .WIDTH(rsn_pkg::ElemW),
    .DEPTH(rsn_pkg::MaxGroups)
  ) u_row_buf (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(cmd.waddr),
    .wdata(element_value),
    .raddr(cmd.raddr),
    .rdata(rdata)
  );

  assign prefix_next = prefix + {{(rsn_pkg::TotalW-rsn_pkg::ElemW){1'b0}}, rdata};

  // first step compares without shifting, giving the integer bit
  assign rem_shift = cmd.div_first ? rem : {rem[rsn_pkg::TotalW-1:0], 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      prefix <= '0;
    end else begin
      if (cmd.load) begin
        total <= total + {{(rsn_pkg::TotalW-rsn_pkg::ElemW){1'b0}}, element_value};
      end
      if (cmd.acc) begin
        prefix <= prefix_next;
      end
      if (cmd.clear_row) begin
        total  <= '0;
        prefix <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      rem  <= {1'b0, prefix_next};
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_shift - {1'b0, total}) : rem_shift;
      quot <= {quot[rsn_pkg::QuotW-2:0], rem_ge};
    end
  end

  assign status.zero_total = (total == '0);

  assign zero_sum  = status.zero_total;
  assign cdf_value = status.zero_total ? '0 : quot;
  assign row_total = total;

endmodule

// ===== src/rsn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsn_ctrl
// Sequencer: loads a row, then walks the buffer element by element, running
// the divider for each unless the row sum is zero; one result per element.
// ----------------------------------------------------------------------------
module rsn_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rsn_pkg::CountW-1:0]   eff_len,
  input  rsn_pkg::status_t             status,
  output rsn_pkg::cmd_t                cmd,
  output logic                         busy,
  output logic                         valid,
  output logic                         row_last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                        state;
  logic [rsn_pkg::CountW-1:0]    count;
  logic [rsn_pkg::CountW-1:0]    count_next;
  logic [rsn_pkg::IdxW-1:0]      idx;
  logic [rsn_pkg::BitCntW-1:0]   bitcnt;
  logic                          last;

  assign count_next = count + 1'b1;
  assign last       = ({1'b0, idx} + 1'b1) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      idx    <= '0;
      bitcnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            count <= count_next;
            if (count_next >= eff_len) begin
              state <= S_RD;
              idx   <= '0;
            end
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          bitcnt <= '0;
          state  <= status.zero_total ? S_OUT : S_DIV;
        end
        S_DIV: begin
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == '1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          idx <= idx + 1'b1;
          if (last) begin
            state <= S_IDLE;
            count <= '0;
          end else begin
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && start;
    cmd.waddr     = count[rsn_pkg::IdxW-1:0];
    cmd.raddr     = idx;
    cmd.acc       = (state == S_ACC);
    cmd.div_step  = (state == S_DIV);
    cmd.div_first = (bitcnt == '0);
    cmd.clear_row = (state == S_OUT) && last;
  end

  assign busy     = (state != S_IDLE);
  assign valid    = (state == S_OUT);
  assign row_last = valid && last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rsn_pkg::CountW'(rsn_pkg::MaxGroups))
    else $error("element count beyond buffer depth");

  a_out_next: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> state == S_IDLE || state == S_RD)
    else $error("bad state after result");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && bitcnt == '1 |=> state == S_OUT)
    else $error("divider did not finish after last step");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy && !valid)
    else $error("element stored while emitting");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks row_sum_normalize_cdf_unit against a predictor of the row buffer,
// running total and normalized prefix sums. Rows of many lengths and value
// mixes are sent with random gaps, and num_groups is changed between rows
// and in the middle of rows. Every result strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int ItemTarget = 370;
  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [rsn_pkg::QuotW-1:0]  cdf;
    logic [rsn_pkg::TotalW-1:0] total;
    logic                       zero;
    logic                       last;
  } cdf_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [rsn_pkg::ElemW-1:0]  element_value = '0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic                       busy;
  logic                       valid;
  logic [rsn_pkg::QuotW-1:0]  cdf_value;
  logic [rsn_pkg::TotalW-1:0] row_total;
  logic                       zero_sum;
  logic                       row_last;
  logic [31:0]                prdata;
  logic                       pready;

  // predictor state
  logic [rsn_pkg::ElemW-1:0]  row_mem [rsn_pkg::MaxGroups];
  logic [rsn_pkg::TotalW-1:0] row_sum;
  logic [6:0]                 elem_cnt;
  logic [6:0]                 groups_cfg;
  cdf_result_t                pending_cdf[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int rows_done = 0;
  int cycles = 0;

  row_sum_normalize_cdf_unit u_dut (
    .clk, .rst, .start, .busy, .element_value,
    .valid, .cdf_value, .row_total, .zero_sum, .row_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[row_sum_normalize_cdf_unit] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] exp_v,
                        input logic [63:0] got_v);
    $display("mismatch %s: expected 0x%0h got 0x%0h (result %0d)",
             what, exp_v, got_v, results_seen);
    errors++;
  endtask

  // compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    cdf_result_t e;
    if (!rst && valid) begin
      if (pending_cdf.size() == 0) begin
        report("unexpected result", 64'd0, {32'd0, cdf_value});
      end else begin
        e = pending_cdf.pop_front();
        if (cdf_value !== e.cdf) report("cdf_value", 64'(e.cdf), 64'(cdf_value));
        if (row_total !== e.total) report("row_total", 64'(e.total), 64'(row_total));
        if (zero_sum !== e.zero) report("zero_sum", 64'(e.zero), 64'(zero_sum));
        if (row_last !== e.last) report("row_last", 64'(e.last), 64'(row_last));
      end
      results_seen++;
    end
  end

  task automatic queue_expected(input cdf_result_t r);
    pending_cdf.insert(pending_cdf.size(), r);
  endtask

  // store an accepted item and, when the row is complete, queue its results
  task automatic predict_row_item(input logic [rsn_pkg::ElemW-1:0] v);
    int unsigned eff, n;
    logic [rsn_pkg::TotalW-1:0] prefix;
    logic [69:0] q;
    cdf_result_t r;
    row_mem[elem_cnt % rsn_pkg::MaxGroups] = v;
    row_sum = row_sum + rsn_pkg::TotalW'(v);
    elem_cnt = elem_cnt + 7'd1;
    eff = (groups_cfg == 0) ? 1 :
          (groups_cfg > rsn_pkg::MaxGroups) ? rsn_pkg::MaxGroups : groups_cfg;
    if (elem_cnt < eff) return;
    n = (elem_cnt > rsn_pkg::MaxGroups) ? rsn_pkg::MaxGroups : elem_cnt;
    prefix = '0;
    for (int k = 0; k < n; k++) begin
      prefix = prefix + rsn_pkg::TotalW'(row_mem[k]);
      if (row_sum == 0) begin
        r.cdf = '0;
        r.total = '0;
        r.zero = 1'b1;
      end else begin
        q = {prefix, 31'd0} / 70'(row_sum);
        if (q > 70'h8000_0000) q = 70'h8000_0000;
        r.cdf = q[rsn_pkg::QuotW-1:0];
        r.total = row_sum;
        r.zero = 1'b0;
      end
      r.last = (k + 1 == n);
      queue_expected(r);
    end
    row_sum = '0;
    elem_cnt = '0;
    rows_done++;
  endtask

  // start stays high across back-to-back items
  task automatic send_element(input logic [rsn_pkg::ElemW-1:0] v);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (busy);
    predict_row_item(v);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cdf.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_groups(input logic [6:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {rsn_pkg::RegNumGroups, 2'b00};
    pwdata <= {25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    groups_cfg = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[6:0] !== v) report("num_groups readback", 64'(v), 64'(prdata[6:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [rsn_pkg::ElemW-1:0] pick_value(input int mix);
    case (mix)
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return '0;
      3: return '1;
      default: return ($urandom_range(0, 2) == 0) ? '0 : $urandom();
    endcase
  endfunction

  task automatic test_single_rows();
    set_groups(7'd1);
    send_element('0);
    send_element('1);
    send_element(32'h0001_0000);
    set_groups(7'd0);
    send_element(32'h8000_0001);
  endtask

  task automatic test_short_rows();
    set_groups(7'd2);
    send_element('0);
    send_element('0);
    send_element('1);
    send_element('1);
    send_element('0);
    send_element(32'd1);
    send_element(32'd3);
    send_element('1);
  endtask

  task automatic test_length_change_mid_row();
    set_groups(7'd4);
    repeat (3) send_element($urandom());
    set_groups(7'd2);
    send_element($urandom());
    set_groups(7'd5);
    repeat (2) send_element($urandom_range(0, 15));
    set_groups(7'd0);
    send_element(32'd7);
  endtask

  task automatic test_random_rows();
    int unsigned cfg, eff, count, mix;
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0: cfg = ($urandom_range(0, 1) == 0) ? rsn_pkg::MaxGroups : 127;
        1: cfg = $urandom_range(rsn_pkg::MaxGroups + 1, 126);
        default: cfg = $urandom_range(0, 8);
      endcase
      set_groups(7'(cfg));
      eff = (cfg == 0) ? 1 : (cfg > rsn_pkg::MaxGroups) ? rsn_pkg::MaxGroups : cfg;
      count = (eff > 8) ? eff : eff * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(0, eff - 1);
      if (count > ItemTarget - items_sent) count = ItemTarget - items_sent;
      mix = $urandom_range(0, 5);
      for (int i = 0; i < count; i++) begin
        send_element(pick_value(mix == 5 ? $urandom_range(0, 4) : mix));
      end
    end
  endtask

  initial begin
    groups_cfg = 7'd64;
    row_sum = '0;
    elem_cnt = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_rows();
    test_short_rows();
    test_length_change_mid_row();
    test_random_rows();
    wait_idle();
    $display("sent %0d elements, %0d rows completed, %0d results checked",
             items_sent, rows_done, results_seen);
    $display("row lengths 0..127 incl. saturation, zero and full-scale rows");
    if (errors == 0) begin
      $display("[row_sum_normalize_cdf_unit] OK");
    end else begin
      $display("[row_sum_normalize_cdf_unit] ERROR");
    end
    $finish;
  end
endmodule
